// File: hdl/lph_pkg.sv
// Shared types and constants of the linear-probing hash table.
// Field widths, result codes and the control/flag bundles between sequencer and datapath.
// No dependencies.
package lph_pkg;

  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // datapath controls, one field of the control word each
  typedef struct packed {
    logic accept;    // take an input item
    logic clr;       // clear one slot of the table
    logic mod_step;  // advance the remainder unit by one phase
    logic load_pos;  // start the probe at the home slot
    logic probe;     // examine one slot
    logic post;      // hand the result to the output register
  } ctrl_t;

  // datapath conditions tested by the sequencer
  typedef struct packed {
    logic accept;
    logic clr_last;
    logic mod_last;
    logic probe_end;
    logic out_free;
  } flags_t;

endpackage

// File: hdl/lph_mod.sv
// Remainder unit: key modulo the table size by reciprocal multiplication, then a low-bit subtraction.
// Depends on lph_pkg.
module lph_mod import lph_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [KEY_W-1:0]              key,
  output logic [$clog2(TABLE_SIZE)-1:0] rem,
  output logic                          last
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int SHIFT = KEY_W + IDX_W;
  // rounded-up reciprocal; exact quotient for every key below 2**KEY_W
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [KEY_W:0]   RECIP    = RECIP_WIDE[KEY_W:0];
  localparam logic [IDX_W-1:0] SIZE_LOW = IDX_W'(TABLE_SIZE);

  logic [KEY_W-1:0] k;
  logic [2*KEY_W:0] prod;
  logic             phase;
  logic [IDX_W-1:0] quot_low;
  logic [IDX_W-1:0] qd_low;

  // the remainder is below the table size, so the low bits of key - q * size suffice
  assign quot_low = prod[SHIFT +: IDX_W];
  assign qd_low   = quot_low * SIZE_LOW;

  assign last = step && phase;

  always_ff @(posedge clk) begin
    if (start) begin
      k     <= key;
      phase <= 1'b0;
    end else if (step) begin
      if (!phase) begin
        prod <= k * RECIP;
      end else begin
        rem <= k[IDX_W-1:0] - qd_low;
      end
      phase <= ~phase;
    end
  end

endmodule

// File: hdl/lph_dp.sv
// Datapath: slot memory, probe pointer, decision logic and output register.
// Depends on lph_pkg and lph_mod.
module lph_dp import lph_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctl,
  output flags_t              flags,
  input  logic                in_valid,
  input  op_t                 in_op,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output status_t             out_status,
  output logic [SLOT_W-1:0]   out_slot
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

  logic [KEY_W:0]     mem [TABLE_SIZE];
  logic [KEY_W:0]     rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [KEY_W:0]     wr_data;
  logic               wr_en;

  op_t                op;
  logic [KEY_W-1:0]   key;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   pos_next;
  logic [IDX_W-1:0]   probe_n;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   home;
  logic               accept;
  logic               mod_last;
  logic               done;
  logic               ins_we;
  status_t            dec_status;
  logic [SLOT_W-1:0]  dec_slot;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic               out_free;

  assign accept = ctl.accept & in_valid;

  lph_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk   (clk),
    .start (accept),
    .step  (ctl.mod_step),
    .key   (in_key),
    .rem   (home),
    .last  (mod_last)
  );

  assign pos_next = (pos == LAST_SLOT) ? '0 : pos + 1'b1;

  // decide on the slot whose word was read last cycle
  always_comb begin
    done       = 1'b0;
    ins_we     = 1'b0;
    dec_status = ST_NOT_FOUND;
    dec_slot   = '0;
    if (op == OP_INSERT) begin
      if (!rd_data[KEY_W]) begin
        done       = 1'b1;
        ins_we     = 1'b1;
        dec_status = ST_INSERTED;
        dec_slot   = SLOT_W'(pos);
      end else if (probe_n == LAST_SLOT) begin
        done       = 1'b1;
        dec_status = ST_FULL;
      end
    end else begin
      if (!rd_data[KEY_W]) begin
        done = 1'b1;
      end else if (rd_data[KEY_W-1:0] == key) begin
        done       = 1'b1;
        dec_status = ST_FOUND;
        dec_slot   = SLOT_W'(pos);
      end else if (probe_n == LAST_SLOT) begin
        done = 1'b1;
      end
    end
  end

  // read the home slot first, then always one slot ahead
  assign rd_addr = ctl.load_pos ? home : pos_next;
  assign wr_en   = ctl.clr | (ctl.probe & ins_we);
  assign wr_addr = ctl.clr ? clr_addr : pos;
  assign wr_data = ctl.clr ? '0 : {1'b1, key};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign out_free = !out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (ctl.post && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= in_op;
      key <= in_key;
    end
    if (ctl.load_pos) begin
      pos     <= home;
      probe_n <= '0;
    end else if (ctl.probe && !done) begin
      pos     <= pos_next;
      probe_n <= probe_n + 1'b1;
    end
    if (ctl.probe && done) begin
      res_status <= dec_status;
      res_slot   <= dec_slot;
    end
    if (ctl.post && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end

  assign flags.accept    = accept;
  assign flags.clr_last  = ctl.clr & (clr_addr == LAST_SLOT);
  assign flags.mod_last  = mod_last;
  assign flags.probe_end = ctl.probe & done;
  assign flags.out_free  = out_free;

endmodule

// File: hdl/lph_seq.sv
// Microcoded sequencer: step counter, control store and jump conditions.
// Depends on lph_pkg.
module lph_seq import lph_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctl
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MOD, S_READ, S_PROBE, S_POST
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_CLR_LAST, C_ACCEPT, C_MOD_LAST, C_PROBE_END, C_OUT_FREE
  } cond_t;

  // stay on the step until the condition holds, then jump
  typedef struct packed {
    ctrl_t ctl;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode(step_t s);
    ucode_t w;
    w = '{ctl: '0, cond: C_ALWAYS, target: S_IDLE};
    unique case (s)
      S_CLR:   begin w.ctl.clr      = 1'b1; w.cond = C_CLR_LAST;  w.target = S_IDLE;  end
      S_IDLE:  begin w.ctl.accept   = 1'b1; w.cond = C_ACCEPT;    w.target = S_MOD;   end
      S_MOD:   begin w.ctl.mod_step = 1'b1; w.cond = C_MOD_LAST;  w.target = S_READ;  end
      S_READ:  begin w.ctl.load_pos = 1'b1; w.cond = C_ALWAYS;    w.target = S_PROBE; end
      S_PROBE: begin w.ctl.probe    = 1'b1; w.cond = C_PROBE_END; w.target = S_POST;  end
      S_POST:  begin w.ctl.post     = 1'b1; w.cond = C_OUT_FREE;  w.target = S_IDLE;  end
      default: w = '{ctl: '0, cond: C_ALWAYS, target: S_IDLE};
    endcase
    return w;
  endfunction

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   go;

  always_comb begin
    word = ucode(step);
    ctl  = word.ctl;
    unique case (word.cond)
      C_ALWAYS:    go = 1'b1;
      C_CLR_LAST:  go = flags.clr_last;
      C_ACCEPT:    go = flags.accept;
      C_MOD_LAST:  go = flags.mod_last;
      C_PROBE_END: go = flags.probe_end;
      C_OUT_FREE:  go = flags.out_free;
      default:     go = 1'b1;
    endcase
    step_next = go ? word.target : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLR;
    end else begin
      step <= step_next;
    end
  end

  a_accept_starts_mod: assert property (@(posedge clk) disable iff (rst)
    flags.accept |=> step == S_MOD)
    else $error("accepted item did not start the remainder");

  a_probe_exit: assert property (@(posedge clk) disable iff (rst)
    step == S_PROBE |=> step == S_PROBE || step == S_POST)
    else $error("probe left by an unexpected path");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    step == S_CLR |-> !ctl.accept && !ctl.probe)
    else $error("item taken during the clearing pass");

endmodule

// File: hdl/linear_probe_hash_table.sv
// Top level of the linear-probing hash table: stream ports, sequencer and datapath.
// Depends on lph_pkg, lph_seq and lph_dp.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: key[30:0], zero[31]; tuser: operation
//  m_axis   | out       | tdata: status[1:0], slot[5:2], zero[7:6]
//
// One item at a time. An item is taken on the idle step; the remainder unit
// forms the home slot (reciprocal multiply, then the low remainder bits); the
// read step fetches the home slot; the probe step examines one slot a cycle
// (1 to TABLE_SIZE slots, one read port with registered data); the hand-over
// step moves the result to the output register.
// After reset a clearing pass writes every slot empty, one slot a cycle;
// s_axis_tready stays low meanwhile.
// A result waiting on m_axis does not block taking the next item; a finished
// probe holds in the hand-over step until the output register is free.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[30:0], unused[31]
  input  logic                  s_axis_tuser,   // operation[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // status[1:0], slot[5:2], zero[7:6]
);

  ctrl_t             ctl;
  flags_t            flags;
  status_t           status;
  logic [SLOT_W-1:0] slot;

  // step through the control store; the current word drives the datapath
  lph_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // hold the table, walk the probe path and register the result
  lph_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .flags      (flags),
    .in_valid   (s_axis_tvalid),
    .in_op      (op_t'(s_axis_tuser)),
    .in_key     (s_axis_tdata[KEY_W-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_slot   (slot)
  );

  // ready only on the idle step of the program
  assign s_axis_tready = ctl.accept;

  // pack the result fields, lowest field first, zero fill to the byte
  assign m_axis_tdata = {{(OUT_DATA_W - STATUS_W - SLOT_W){1'b0}}, slot, status};

endmodule

// File: sim/testbench.sv
// Self-checking bench for linear_probe_hash_table: inserts and searches pass through the stream
// ports while a scoreboard class predicts status and slot for every item. Depends on lph_pkg
// and linear_probe_hash_table; no other files.
module testbench import lph_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int SLOT_IDX_W  = $clog2(SLOTS);
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 40;    // extra watch after the last result, for strays

  // one predicted outcome: the status and slot fields that the block packs into m_axis_tdata
  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      slot;
  } outcome_t;

  // Scoreboard: mirrors the table, predicts each accepted item and checks results in order.
  class lookup_checker;
    logic [KEY_W-1:0] mirror_keys [SLOTS];
    bit               mirror_used [SLOTS];
    outcome_t         pending_outcomes [$];
    int               status_tally [4];
    int               mismatches;

    function new();
      foreach (mirror_used[i]) mirror_used[i] = 1'b0;
      foreach (mirror_keys[i]) mirror_keys[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;
      mismatches = 0;
    endfunction

    // Walk the probe path from the home slot, as the block does, and queue the outcome.
    function void note_item(op_t op, logic [KEY_W-1:0] key);
      logic [SLOT_IDX_W-1:0] pos;
      int                    n;
      outcome_t              want;
      pos = SLOT_IDX_W'(key % SLOTS);
      want.slot = '0;
      if (op == OP_INSERT) begin
        want.status = ST_FULL;
        for (n = 0; n < SLOTS; n++) begin
          if (!mirror_used[pos]) begin
            mirror_keys[pos] = key;
            mirror_used[pos] = 1'b1;
            want.status = ST_INSERTED;
            want.slot = SLOT_W'(pos);
            break;
          end
          pos = (pos == SLOT_IDX_W'(SLOTS - 1)) ? '0 : pos + 1'b1;
        end
      end else begin
        want.status = ST_NOT_FOUND;
        for (n = 0; n < SLOTS; n++) begin
          if (!mirror_used[pos]) break;
          if (mirror_keys[pos] == key) begin
            want.status = ST_FOUND;
            want.slot = SLOT_W'(pos);
            break;
          end
          pos = (pos == SLOT_IDX_W'(SLOTS - 1)) ? '0 : pos + 1'b1;
        end
      end
      status_tally[want.status]++;
      pending_outcomes.push_back(want);
    endfunction

    function void check_item(logic [OUT_DATA_W-1:0] data);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%02h", $time, data);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (data[1:0] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, data[1:0]);
        mismatches++;
      end
      if (data[5:2] !== want.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, data[5:2]);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (pending_outcomes.size() == 0);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // key[30:0], zero[31]
  logic                  s_axis_tuser = 1'b0;  // operation[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // status[1:0], slot[5:2], zero[7:6]

  lookup_checker    sb = new();
  logic [KEY_W-1:0] inserted_keys [$];   // every key offered for insertion, for later searches
  int               items_sent = 0;
  int               results_taken = 0;
  int               hold_left = 0;
  bit               held_off = 1'b0;

  linear_probe_hash_table #(.TABLE_SIZE(SLOTS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one item, idling first at random except in the no-gap window, and hold it
  // until the block takes it. Valid stays high straight into the next item when no gap follows.
  task automatic offer_item(input op_t op, input logic [KEY_W-1:0] key);
    while (!(items_sent >= 250 && items_sent < 400) && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, key};
    s_axis_tuser  <= op;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_item(op, key);
    items_sent++;
    if (op == OP_INSERT) inserted_keys.push_back(key);
  endtask

  // Pick a random key: half small ones so that home slots collide, half across all 31 bits.
  function automatic logic [KEY_W-1:0] any_key();
    if ($urandom_range(1)) return KEY_W'($urandom_range(63));
    return KEY_W'($urandom());
  endfunction

  // Result side: check each taken item, then choose the next ready. Hold off once for a long
  // stretch so that results back up into the block and stall its input; never idle in a
  // window of the run.
  always @(posedge clk) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_item(m_axis_tdata);
      results_taken++;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (results_taken == 150 && !held_off) begin
      held_off = 1'b1;
      hold_left = 300;
      m_axis_tready <= 1'b0;
    end else if (results_taken >= 350 && results_taken < 500) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                       i;
    int unsigned              pick;
    logic [KEY_W-1:0]         key;
    logic [$clog2(KEY_W)-1:0] flip;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, collisions on slot 0, duplicates, wrap from the last slot,
    // key extremes, then fill the table and probe it whole.
    offer_item(OP_SEARCH, 31'd5);           // empty table: stop at once
    offer_item(OP_INSERT, 31'd0);
    offer_item(OP_INSERT, 31'h7FFF_FFFF);   // home slot 15
    offer_item(OP_INSERT, 31'd16);          // collides with key 0
    offer_item(OP_INSERT, 31'd0);           // duplicate stored again
    offer_item(OP_SEARCH, 31'd0);
    offer_item(OP_SEARCH, 31'd16);
    offer_item(OP_SEARCH, 31'd32);          // miss ended by an empty slot
    offer_item(OP_INSERT, 31'd31);          // wraps from slot 15 to the front
    offer_item(OP_SEARCH, 31'd31);
    offer_item(OP_SEARCH, 31'h7FFF_FFFF);
    for (i = 0; i < 11; i++) offer_item(OP_INSERT, KEY_W'($urandom()));
    offer_item(OP_INSERT, 31'd7);           // table full
    offer_item(OP_SEARCH, 31'h4000_0000);   // full table: miss after a full pass over every slot
    offer_item(OP_SEARCH, 31'd47);

    // Random: searches of keys offered earlier for insertion, near misses one bit away, fresh keys, and inserts.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        offer_item(OP_INSERT, any_key());
      end else if (pick < 55) begin
        offer_item(OP_SEARCH, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
      end else if (pick < 75) begin
        key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        flip = ($clog2(KEY_W))'($urandom_range(KEY_W - 1));
        key[flip] ^= 1'b1;
        offer_item(OP_SEARCH, key);
      end else begin
        offer_item(OP_SEARCH, any_key());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then watch a little longer for strays.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d inserts stored, %0d refused on a full table,",
             items_sent, sb.status_tally[ST_INSERTED], sb.status_tally[ST_FULL]);
    $display("%0d searches hit and %0d missed; %0d results checked.",
             sb.status_tally[ST_FOUND], sb.status_tally[ST_NOT_FOUND], results_taken);
    if (sb.clean())
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
hdl/lph_pkg.sv
hdl/lph_mod.sv
hdl/lph_dp.sv
hdl/lph_seq.sv
hdl/linear_probe_hash_table.sv
sim/testbench.sv
